/* hdl/pn3s_pkg.sv */
// Shared types, constants and controller commands for the seeded 3-D noise block.
package pn3s_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W = 24;
  localparam int NOISE_W = 18;
  localparam int MUL_W = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DIV_STEPS = 64;

  localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX1 = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX2 = 64'h94D049BB133111EB;
  localparam logic [63:0] ZERO_SUBST = 64'hFF51AFD7ED558CCD;

  localparam logic KIND_BUILD = 1'b0;

  typedef struct packed {
    logic kind;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic [COORD_W-1:0] z_coord;
  } in_item_t;

  typedef struct packed {
    logic signed [NOISE_W-1:0] noise;
    logic built;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_INIT,
    OP_FILL,
    OP_RNG,
    OP_M_LL,
    OP_M_LH,
    OP_M_HL,
    OP_M_FIN,
    OP_MIX,
    OP_DIV,
    OP_RD_I,
    OP_RD_J,
    OP_WR_I,
    OP_WR_J,
    OP_FA,
    OP_FB,
    OP_FC,
    OP_FD,
    OP_FE,
    OP_HASH,
    OP_LM,
    OP_LA,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
    logic [7:0] idx;
    logic [7:0] cnt;
    logic [2:0] sel;
  } cmd_t;

endpackage

/* hdl/pn3s_ctrl.sv */
// Controller state machine that sequences build and evaluate items through the datapath.
module pn3s_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_kind,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output pn3s_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_FILL, S_RNG, S_MUL, S_MIX, S_DIV, S_SWAP,
    S_FADE, S_HASH, S_LERP, S_DONE
  } state_t;

  state_t state_r;
  logic [7:0] cnt_r;
  logic [7:0] idx_r;
  logic [2:0] sel_r;
  logic out_valid_r;
  logic load_out;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    cmd.idx = idx_r;
    cmd.cnt = cnt_r;
    cmd.sel = sel_r;
    unique case (state_r)
      S_IDLE: cmd.op = in_valid ? pn3s_pkg::OP_LOAD : pn3s_pkg::OP_NOP;
      S_INIT: cmd.op = pn3s_pkg::OP_INIT;
      S_FILL: cmd.op = pn3s_pkg::OP_FILL;
      S_RNG: cmd.op = pn3s_pkg::OP_RNG;
      S_MUL: begin
        case (cnt_r[1:0])
          2'd0: cmd.op = pn3s_pkg::OP_M_LL;
          2'd1: cmd.op = pn3s_pkg::OP_M_LH;
          2'd2: cmd.op = pn3s_pkg::OP_M_HL;
          default: cmd.op = pn3s_pkg::OP_M_FIN;
        endcase
      end
      S_MIX: cmd.op = pn3s_pkg::OP_MIX;
      S_DIV: cmd.op = pn3s_pkg::OP_DIV;
      S_SWAP: begin
        case (cnt_r[1:0])
          2'd0: cmd.op = pn3s_pkg::OP_RD_I;
          2'd1: cmd.op = pn3s_pkg::OP_RD_J;
          2'd2: cmd.op = pn3s_pkg::OP_WR_I;
          default: cmd.op = pn3s_pkg::OP_WR_J;
        endcase
      end
      S_FADE: begin
        case (cnt_r[2:0])
          3'd0: cmd.op = pn3s_pkg::OP_FA;
          3'd1: cmd.op = pn3s_pkg::OP_FB;
          3'd2: cmd.op = pn3s_pkg::OP_FC;
          3'd3: cmd.op = pn3s_pkg::OP_FD;
          3'd4: cmd.op = pn3s_pkg::OP_FE;
          default: cmd.op = pn3s_pkg::OP_NOP;
        endcase
      end
      S_HASH: cmd.op = pn3s_pkg::OP_HASH;
      S_LERP: cmd.op = cnt_r[0] ? pn3s_pkg::OP_LA : pn3s_pkg::OP_LM;
      S_DONE: cmd.op = load_out ? pn3s_pkg::OP_OUT : pn3s_pkg::OP_NOP;
      default: cmd.op = pn3s_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      idx_r <= '0;
      sel_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          sel_r <= '0;
          if (in_valid) begin
            state_r <= (in_kind == pn3s_pkg::KIND_BUILD) ? S_INIT : S_FADE;
          end
        end
        S_INIT: begin
          cnt_r <= '0;
          state_r <= S_FILL;
        end
        S_FILL: begin
          cnt_r <= cnt_r + 8'd1;
          if (cnt_r == 8'd255) begin
            idx_r <= 8'd255;
            state_r <= S_RNG;
          end
        end
        S_RNG: begin
          cnt_r <= '0;
          sel_r <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          cnt_r <= cnt_r + 8'd1;
          if (cnt_r[1:0] == 2'd3) begin
            state_r <= S_MIX;
          end
        end
        S_MIX: begin
          cnt_r <= '0;
          if (sel_r == 3'd0) begin
            sel_r <= 3'd1;
            state_r <= S_MUL;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          cnt_r <= cnt_r + 8'd1;
          if (cnt_r == 8'(pn3s_pkg::DIV_STEPS - 1)) begin
            cnt_r <= '0;
            state_r <= S_SWAP;
          end
        end
        S_SWAP: begin
          cnt_r <= cnt_r + 8'd1;
          if (cnt_r[1:0] == 2'd3) begin
            if (idx_r == 8'd1) begin
              state_r <= S_DONE;
            end else begin
              idx_r <= idx_r - 8'd1;
              state_r <= S_RNG;
            end
          end
        end
        S_FADE: begin
          cnt_r <= cnt_r + 8'd1;
          if (cnt_r == 8'd4) begin
            cnt_r <= '0;
            if (sel_r == 3'd2) begin
              sel_r <= '0;
              state_r <= S_HASH;
            end else begin
              sel_r <= sel_r + 3'd1;
            end
          end
        end
        S_HASH: begin
          cnt_r <= cnt_r + 8'd1;
          if (cnt_r == 8'd14) begin
            cnt_r <= '0;
            sel_r <= '0;
            state_r <= S_LERP;
          end
        end
        S_LERP: begin
          cnt_r <= {7'd0, ~cnt_r[0]};
          if (cnt_r[0]) begin
            sel_r <= sel_r + 3'd1;
            if (sel_r == 3'd6) begin
              state_r <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (load_out) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/pn3s_dp.sv */
// Datapath with permutation memory, shared multiplier, remainder unit and noise registers.
module pn3s_dp #(
  parameter int FRAC_BITS = pn3s_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [63:0]          cfg_data,
  input  pn3s_pkg::in_item_t   in_data,
  input  pn3s_pkg::cmd_t       cmd,
  output pn3s_pkg::out_item_t  out_data
);

  localparam int VW = FRAC_BITS + 6;
  localparam int MW = pn3s_pkg::MUL_W;
  localparam int PW = pn3s_pkg::PROD_W;
  localparam int SW = VW + 16;
  localparam int SH_L = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int SH_R = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
  localparam logic signed [VW-1:0] ONE = VW'(1) <<< FRAC_BITS;
  localparam logic signed [SW-1:0] SAT_HI = SW'(131071);
  localparam logic signed [SW-1:0] SAT_LO = -SW'(131072);

  logic [7:0] perm_mem [pn3s_pkg::TABLE_SIZE];
  logic [7:0] rd_r;
  logic [7:0] raddr;
  logic [7:0] waddr;
  logic [7:0] wdata;
  logic we;

  logic [63:0] seed_r, rng_r, v_r, acc_r, dsh_r;
  logic [8:0] rem_r;
  logic [7:0] ti_r;
  logic signed [PW-1:0] prod_r;
  logic signed [MW-1:0] mul_a, mul_b;

  logic kind_r;
  logic [7:0] xi_r, yi_r, zi_r;
  logic [FRAC_BITS-1:0] fx_r, fy_r, fz_r;
  logic signed [VW-1:0] s1_r, bq_r, fu_r, fv_r, fw_r;
  logic [7:0] ha_r, hb_r, haa_r, hab_r, hba_r, hbb_r;
  logic signed [VW-1:0] g_r [8];
  logic signed [VW-1:0] lr_r [6];
  logic signed [VW-1:0] la_r, res_r;
  pn3s_pkg::out_item_t out_r;

  logic [63:0] kc, rng_add, seed_mix;
  logic [8:0] divisor;
  logic [9:0] trial;
  logic [FRAC_BITS-1:0] tf;
  logic signed [VW-1:0] tv, psh, lt;
  logic signed [VW-1:0] la_sel, lb_sel, lerp_sum;
  logic [2:0] kk;
  logic [3:0] gh;
  logic signed [VW-1:0] dx, dy, dz, gu, gv, gval;
  logic signed [SW-1:0] scaled;

  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (we) begin
      perm_mem[waddr] <= wdata;
    end
    rd_r <= perm_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      seed_r <= cfg_data;
    end
  end

  always_comb begin
    kc = (cmd.sel[0]) ? pn3s_pkg::MIX2 : pn3s_pkg::MIX1;
    rng_add = rng_r + pn3s_pkg::GOLDEN;
    seed_mix = seed_r ^ pn3s_pkg::GOLDEN;
    divisor = {1'b0, cmd.idx} + 9'd1;
    trial = {rem_r, dsh_r[63]};
    case (cmd.sel[1:0])
      2'd0: tf = fx_r;
      2'd1: tf = fy_r;
      default: tf = fz_r;
    endcase
    tv = VW'(signed'({1'b0, tf}));
    psh = VW'(prod_r >>> FRAC_BITS);
    kk = cmd.cnt[2:0] + 3'd1;
    gh = rd_r[3:0];
    dx = kk[0] ? (VW'(signed'({1'b0, fx_r})) - ONE) : VW'(signed'({1'b0, fx_r}));
    dy = kk[1] ? (VW'(signed'({1'b0, fy_r})) - ONE) : VW'(signed'({1'b0, fy_r}));
    dz = kk[2] ? (VW'(signed'({1'b0, fz_r})) - ONE) : VW'(signed'({1'b0, fz_r}));
    gu = (gh < 4'd8) ? dx : dy;
    if (gh < 4'd4) begin
      gv = dy;
    end else if (gh == 4'd12 || gh == 4'd14) begin
      gv = dx;
    end else begin
      gv = dz;
    end
    gval = (gh[0] ? -gu : gu) + (gh[1] ? -gv : gv);
    case (cmd.sel)
      3'd0: begin lt = fu_r; la_sel = g_r[0]; lb_sel = g_r[1]; end
      3'd1: begin lt = fu_r; la_sel = g_r[2]; lb_sel = g_r[3]; end
      3'd2: begin lt = fu_r; la_sel = g_r[4]; lb_sel = g_r[5]; end
      3'd3: begin lt = fu_r; la_sel = g_r[6]; lb_sel = g_r[7]; end
      3'd4: begin lt = fv_r; la_sel = lr_r[0]; lb_sel = lr_r[1]; end
      3'd5: begin lt = fv_r; la_sel = lr_r[2]; lb_sel = lr_r[3]; end
      default: begin lt = fw_r; la_sel = lr_r[4]; lb_sel = lr_r[5]; end
    endcase
    lerp_sum = la_r + psh;
    scaled = (SW'(res_r) <<< SH_L) >>> SH_R;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    raddr = cmd.idx;
    waddr = cmd.idx;
    wdata = rd_r;
    we = 1'b0;
    case (cmd.op)
      pn3s_pkg::OP_FILL: begin
        we = 1'b1;
        waddr = cmd.cnt;
        wdata = cmd.cnt;
      end
      pn3s_pkg::OP_M_LL: begin
        mul_a = MW'(signed'({1'b0, v_r[31:0]}));
        mul_b = MW'(signed'({1'b0, kc[31:0]}));
      end
      pn3s_pkg::OP_M_LH: begin
        mul_a = MW'(signed'({1'b0, v_r[31:0]}));
        mul_b = MW'(signed'({1'b0, kc[63:32]}));
      end
      pn3s_pkg::OP_M_HL: begin
        mul_a = MW'(signed'({1'b0, v_r[63:32]}));
        mul_b = MW'(signed'({1'b0, kc[31:0]}));
      end
      pn3s_pkg::OP_RD_J: raddr = rem_r[7:0];
      pn3s_pkg::OP_WR_I: we = 1'b1;
      pn3s_pkg::OP_WR_J: begin
        we = 1'b1;
        waddr = rem_r[7:0];
        wdata = ti_r;
      end
      pn3s_pkg::OP_FA: begin
        mul_a = MW'(tv);
        mul_b = MW'(tv);
      end
      pn3s_pkg::OP_FB: begin
        mul_a = MW'(tv);
        mul_b = MW'(VW'(6) * tv - VW'(15) * ONE);
      end
      pn3s_pkg::OP_FC: begin
        mul_a = MW'(s1_r);
        mul_b = MW'(tv);
      end
      pn3s_pkg::OP_FD: begin
        mul_a = MW'(psh);
        mul_b = MW'(bq_r);
      end
      pn3s_pkg::OP_HASH: begin
        case (cmd.cnt[3:0])
          4'd0: raddr = xi_r;
          4'd1: raddr = xi_r + 8'd1;
          4'd2: raddr = ha_r;
          4'd3: raddr = ha_r + 8'd1;
          4'd4: raddr = hb_r;
          4'd5: raddr = hb_r + 8'd1;
          4'd6: raddr = haa_r;
          4'd7: raddr = hba_r;
          4'd8: raddr = hab_r;
          4'd9: raddr = hbb_r;
          4'd10: raddr = haa_r + 8'd1;
          4'd11: raddr = hba_r + 8'd1;
          4'd12: raddr = hab_r + 8'd1;
          default: raddr = hbb_r + 8'd1;
        endcase
      end
      pn3s_pkg::OP_LM: begin
        mul_a = MW'(lt);
        mul_b = MW'(lb_sel - la_sel);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (cmd.op)
      pn3s_pkg::OP_LOAD: begin
        kind_r <= in_data.kind;
        xi_r <= 8'(in_data.x_coord >> FRAC_BITS);
        yi_r <= 8'(in_data.y_coord >> FRAC_BITS);
        zi_r <= 8'(in_data.z_coord >> FRAC_BITS);
        fx_r <= in_data.x_coord[FRAC_BITS-1:0];
        fy_r <= in_data.y_coord[FRAC_BITS-1:0];
        fz_r <= in_data.z_coord[FRAC_BITS-1:0];
      end
      pn3s_pkg::OP_INIT: rng_r <= (seed_mix == 64'd0) ? pn3s_pkg::ZERO_SUBST : seed_mix;
      pn3s_pkg::OP_RNG: begin
        rng_r <= rng_add;
        v_r <= rng_add ^ (rng_add >> 30);
      end
      pn3s_pkg::OP_M_LH: acc_r <= prod_r[63:0];
      pn3s_pkg::OP_M_HL, pn3s_pkg::OP_M_FIN: acc_r <= acc_r + {prod_r[31:0], 32'd0};
      pn3s_pkg::OP_MIX: begin
        if (cmd.sel[0]) begin
          dsh_r <= acc_r ^ (acc_r >> 31);
          rem_r <= '0;
        end else begin
          v_r <= acc_r ^ (acc_r >> 27);
        end
      end
      pn3s_pkg::OP_DIV: begin
        dsh_r <= {dsh_r[62:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          rem_r <= 9'(trial - {1'b0, divisor});
        end else begin
          rem_r <= trial[8:0];
        end
      end
      pn3s_pkg::OP_RD_J: ti_r <= rd_r;
      pn3s_pkg::OP_FB: s1_r <= psh;
      pn3s_pkg::OP_FC: bq_r <= psh + VW'(10) * ONE;
      pn3s_pkg::OP_FE: begin
        case (cmd.sel[1:0])
          2'd0: fu_r <= psh;
          2'd1: fv_r <= psh;
          default: fw_r <= psh;
        endcase
      end
      pn3s_pkg::OP_HASH: begin
        case (cmd.cnt[3:0])
          4'd1: ha_r <= rd_r + yi_r;
          4'd2: hb_r <= rd_r + yi_r;
          4'd3: haa_r <= rd_r + zi_r;
          4'd4: hab_r <= rd_r + zi_r;
          4'd5: hba_r <= rd_r + zi_r;
          4'd6: hbb_r <= rd_r + zi_r;
          default: begin
          end
        endcase
        if (cmd.cnt[3:0] >= 4'd7) begin
          for (int k = 0; k < 7; k++) begin
            g_r[k] <= g_r[k+1];
          end
          g_r[7] <= gval;
        end
      end
      pn3s_pkg::OP_LM: la_r <= la_sel;
      pn3s_pkg::OP_LA: begin
        if (cmd.sel == 3'd6) begin
          res_r <= lerp_sum;
        end else begin
          lr_r[cmd.sel] <= lerp_sum;
        end
      end
      pn3s_pkg::OP_OUT: begin
        out_r.built <= ~kind_r;
        if (kind_r == pn3s_pkg::KIND_BUILD) begin
          out_r.noise <= '0;
        end else if (scaled > SAT_HI) begin
          out_r.noise <= SAT_HI[pn3s_pkg::NOISE_W-1:0];
        end else if (scaled < SAT_LO) begin
          out_r.noise <= SAT_LO[pn3s_pkg::NOISE_W-1:0];
        end else begin
          out_r.noise <= scaled[pn3s_pkg::NOISE_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* hdl/perlin_noise_3d_seeded.sv */
// Top level of the seeded 3-D improved Perlin noise block.
// The input channel (in_valid, in_ready, in_data) takes one item at a time. An item of
// kind 0 rebuilds the 256-entry permutation from the seed register by a shuffle; an
// item of kind 1 evaluates noise at three unsigned fixed-point coordinates.
// Each item gives one result item on the output channel (out_valid, out_ready, out_data).
// A build item loads the identity table, then runs 255 shuffle steps, each using the
// 64-step remainder unit and the shared 33x33 multiplier, which forms the generator's
// 64-bit products in four passes. An evaluate item runs three fades on the multiplier,
// table reads on the single memory read port, and seven interpolations.
// The seed is written through cfg_valid, cfg_ready and cfg_data; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// The block takes a new item only when the previous one has finished; a finished result
// sits in the output register, so the next item is accepted while it waits.
// When the receiver stalls, a finished item waits until the output register is free.
// Reset clears the controller, the output valid and the seed register; the table is
// undefined until written, so a build must precede any evaluation.
module perlin_noise_3d_seeded #(
  parameter int FRAC_BITS = pn3s_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pn3s_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pn3s_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [63:0]          cfg_data
);

  pn3s_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  pn3s_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_data.kind),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  pn3s_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule
